// ----- hw/rtl/arp_ipv4_tcp_receive_classifier_unit_macros.svh -----
// Assertion macros for the receive classifier.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef ARP_IPV4_TCP_RECEIVE_CLASSIFIER_UNIT_MACROS_SVH
`define ARP_IPV4_TCP_RECEIVE_CLASSIFIER_UNIT_MACROS_SVH
`ifndef SYNTH
`define AITC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aitc: check failed");
`define AITC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aitc: check failed");
`else
`define AITC_ASSERT_IMP(lbl, ante, cons)
`define AITC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/aitc_pkg.sv -----
// Types and constants of the receive classifier.
// No dependencies.
`timescale 1ns / 1ps
package aitc_pkg;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [7:0]  TCP_SYNACK = 8'h12;
    localparam logic [7:0]  TCP_FIN    = 8'h01;
    localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
    localparam logic [15:0] ARP_OP_REQ = 16'd1;
    localparam logic [15:0] ARP_OP_REP = 16'd2;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCAL_IP   = 3'd0,
        REG_GATEWAY_IP = 3'd1,
        REG_PEER_IP    = 3'd2,
        REG_LOCAL_PORT = 3'd3,
        REG_PEER_PORT  = 3'd4,
        REG_CONN_EN    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CONN_CLOSED      = 2'd0,
        CONN_SYN_SENT    = 2'd1,
        CONN_ESTABLISHED = 2'd2,
        CONN_FIN_WAIT    = 2'd3
    } conn_state_t;

    typedef enum logic [2:0] {
        VERD_DROP     = 3'd0,
        VERD_ARP_REQ  = 3'd1,
        VERD_GW_MAC   = 3'd2,
        VERD_ESTAB    = 3'd3,
        VERD_DATA_ACK = 3'd4,
        VERD_FIN_ACK  = 3'd5,
        VERD_BARE_ACK = 3'd6
    } verdict_t;
endpackage

// ----- hw/rtl/aitc_ifs.sv -----
// Channel interfaces of the receive classifier: frame bytes, results, config.
// Depends on aitc_pkg.
`timescale 1ns / 1ps
interface aitc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;
    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface aitc_result_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [2:0]  verdict;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] ack_number;
    logic [1:0]  conn_state;
    modport source (output valid, payload_valid, payload_byte, frame_done, verdict,
                    sender_mac, sender_ip, ack_number, conn_state, input ready);
    modport sink   (input valid, payload_valid, payload_byte, frame_done, verdict,
                    sender_mac, sender_ip, ack_number, conn_state, output ready);
endinterface

interface aitc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aitc_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/arp_ipv4_tcp_receive_classifier_unit.sv -----
// Receive classifier top level: header capture, checks, TCP receive machine.
// Depends on aitc_pkg, aitc_ifs and the assertion macro header.
//
// Usage:
//  frame  : one received Ethernet byte per beat, frame_last on the final byte.
//  result : exactly one beat per frame byte. payload_valid/payload_byte carry
//           in-order TCP payload; on the last byte frame_done is set and
//           verdict, sender_mac, sender_ip hold the frame's outcome.
//           ack_number and conn_state follow every beat.
//  cfg    : register writes (index 0..5), always ready; write only when idle.
//           An offered write takes the cycle, the frame channel waits.
// Timing: each result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per clock; the result register is the only stage,
//  so frame.ready drops only while a held result is not taken or while a
//  register write is offered.
// Reset: connection CLOSED, expected sequence 0, registers at defaults.
// Stall: a stalled result holds; input stops until it is taken.
`timescale 1ns / 1ps
`include "arp_ipv4_tcp_receive_classifier_unit_macros.svh"
module arp_ipv4_tcp_receive_classifier_unit #(
    parameter int MAX_FRAME = 2048
) (
    input  logic         clk,
    input  logic         rst_n,
    aitc_frame_if.sink   frame,
    aitc_result_if.source result,
    aitc_cfg_if.sink     cfg
);
    localparam int PW = $clog2(MAX_FRAME + 1);

    // config registers
    logic [31:0] local_ip_reg, gateway_ip_reg, peer_ip_reg;
    logic [15:0] local_port_reg, peer_port_reg;

    // frame and connection state
    aitc_pkg::conn_state_t conn_reg, conn_next;
    logic [31:0] exp_seq_reg, exp_seq_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0] eth_type_reg, eth_type_next, arp_op_reg, arp_op_next;
    logic [47:0] arp_hw_reg, arp_hw_next;
    logic [31:0] arp_spa_reg, arp_spa_next, arp_tpa_reg, arp_tpa_next;
    logic [5:0]  ihl_reg, ihl_next, thl_reg, thl_next;
    logic [15:0] tot_len_reg, tot_len_next;
    logic [7:0]  proto_reg, proto_next, flags_reg, flags_next;
    logic [31:0] ip_src_reg, ip_src_next, ip_dst_reg, ip_dst_next;
    logic [15:0] sport_reg, sport_next, dport_reg, dport_next;
    logic [31:0] seq_reg, seq_next;
    logic        rej_reg, rej_next, acc_reg, acc_next;

    // result register
    logic        out_vld_reg;
    logic        pv_reg, pv_next, done_reg, done_next;
    logic [7:0]  pb_reg, pb_next;
    aitc_pkg::verdict_t verd_reg, verd_next;
    logic [47:0] smac_reg, smac_next;
    logic [31:0] sip_reg, sip_next;

    logic          in_fire, cfg_fire, in_win, conn_ok;
    logic [PW-1:0] p, q;
    logic [16:0]   p17, hdr_end, ip_end;
    logic signed [19:0] len_s, ip_off, tcp_off, pay_raw, pay_lim, pay;

    // a register write owns the cycle, so a byte and a write never land together
    assign frame.ready = (!out_vld_reg || result.ready) && !cfg.valid;
    assign cfg.ready   = 1'b1;
    assign in_fire     = frame.valid && frame.ready;
    assign cfg_fire    = cfg.valid && cfg.ready;

    always_comb
    begin
        conn_next = conn_reg;       exp_seq_next = exp_seq_reg;
        pos_next = pos_reg;         eth_type_next = eth_type_reg;
        arp_op_next = arp_op_reg;   arp_hw_next = arp_hw_reg;
        arp_spa_next = arp_spa_reg; arp_tpa_next = arp_tpa_reg;
        ihl_next = ihl_reg;         thl_next = thl_reg;
        tot_len_next = tot_len_reg; proto_next = proto_reg;
        flags_next = flags_reg;     ip_src_next = ip_src_reg;
        ip_dst_next = ip_dst_reg;   sport_next = sport_reg;
        dport_next = dport_reg;     seq_next = seq_reg;
        rej_next = rej_reg;         acc_next = acc_reg;
        pv_next = 1'b0; pb_next = 8'd0; done_next = frame.frame_last;
        verd_next = aitc_pkg::VERD_DROP; smac_next = 48'd0; sip_next = 32'd0;
        p = pos_reg;
        p17 = 17'(pos_reg);
        q = '0; hdr_end = '0; ip_end = '0; conn_ok = 1'b0;
        len_s = '0; ip_off = '0; tcp_off = '0; pay_raw = '0; pay_lim = '0; pay = '0;
        in_win = pos_reg < PW'(MAX_FRAME);

        if (in_win)
        begin
            // capture header fields by position
            if (p == PW'(12) || p == PW'(13)) eth_type_next = {eth_type_next[7:0], frame.frame_byte};
            if (p == PW'(20) || p == PW'(21)) arp_op_next = {arp_op_next[7:0], frame.frame_byte};
            if (p >= PW'(22) && p <= PW'(27)) arp_hw_next = {arp_hw_next[39:0], frame.frame_byte};
            if (p >= PW'(28) && p <= PW'(31)) arp_spa_next = {arp_spa_next[23:0], frame.frame_byte};
            if (p >= PW'(38) && p <= PW'(41)) arp_tpa_next = {arp_tpa_next[23:0], frame.frame_byte};
            if (p == PW'(14))
            begin
                rej_next = frame.frame_byte[7:4] != 4'd4;
                ihl_next = {frame.frame_byte[3:0], 2'b00};
            end
            if (p == PW'(16) || p == PW'(17)) tot_len_next = {tot_len_next[7:0], frame.frame_byte};
            if (p == PW'(23)) proto_next = frame.frame_byte;
            if (p >= PW'(26) && p <= PW'(29)) ip_src_next = {ip_src_next[23:0], frame.frame_byte};
            if (p >= PW'(30) && p <= PW'(33)) ip_dst_next = {ip_dst_next[23:0], frame.frame_byte};
            if (ihl_next >= 6'd20 && p17 >= 17'd14 + 17'(ihl_next))
            begin
                q = p - PW'(14) - PW'(ihl_next);
                if (q <= PW'(1)) sport_next = {sport_next[7:0], frame.frame_byte};
                else if (q <= PW'(3)) dport_next = {dport_next[7:0], frame.frame_byte};
                else if (q <= PW'(7)) seq_next = {seq_next[23:0], frame.frame_byte};
                else if (q == PW'(12)) thl_next = {frame.frame_byte[7:4], 2'b00};
                else if (q == PW'(13)) flags_next = frame.frame_byte;
            end

            conn_ok = conn_reg != aitc_pkg::CONN_CLOSED && ip_src_next == peer_ip_reg &&
                      dport_next == local_port_reg && sport_next == peer_port_reg;
            hdr_end = 17'd14 + 17'(ihl_next) + 17'(thl_next);
            // stream decision at the first payload byte
            if (ihl_next >= 6'd20 && thl_next >= 6'd20 && p17 == hdr_end &&
                eth_type_next == aitc_pkg::ETH_IPV4 && !rej_next &&
                17'(tot_len_next) >= 17'(ihl_next) && ip_dst_next == local_ip_reg &&
                proto_next == aitc_pkg::IP_PROTO_TCP && conn_ok &&
                (conn_reg == aitc_pkg::CONN_ESTABLISHED ||
                 conn_reg == aitc_pkg::CONN_FIN_WAIT) &&
                seq_next == exp_seq_reg &&
                17'(tot_len_next) > 17'(ihl_next) + 17'(thl_next))
                acc_next = 1'b1;
            ip_end = 17'd14 + 17'(tot_len_next);
            if (acc_next && p17 < ip_end)
            begin
                pv_next = 1'b1;
                pb_next = frame.frame_byte;
            end
            pos_next = pos_reg + PW'(1);
        end

        conn_ok = conn_reg != aitc_pkg::CONN_CLOSED && ip_src_next == peer_ip_reg &&
                  dport_next == local_port_reg && sport_next == peer_port_reg;

        if (frame.frame_last)
        begin
            len_s   = 20'(pos_next);
            ip_off  = 20'sd14 + 20'(ihl_next);
            tcp_off = ip_off + 20'(thl_next);
            pay_raw = 20'(tot_len_next) - 20'(ihl_next) - 20'(thl_next);
            pay_lim = len_s - tcp_off;
            pay     = (pay_raw < 20'sd0) ? 20'sd0 : pay_raw;
            if (pay > pay_lim) pay = pay_lim;

            if (len_s < 20'sd14)
                verd_next = aitc_pkg::VERD_DROP;
            else if (eth_type_next == aitc_pkg::ETH_ARP)
            begin
                if (len_s < 20'sd42)
                    verd_next = aitc_pkg::VERD_DROP;
                else if (arp_op_next == aitc_pkg::ARP_OP_REP && arp_spa_next == gateway_ip_reg)
                    verd_next = aitc_pkg::VERD_GW_MAC;
                else if (arp_op_next == aitc_pkg::ARP_OP_REQ && arp_tpa_next == local_ip_reg)
                    verd_next = aitc_pkg::VERD_ARP_REQ;
            end
            else if (eth_type_next != aitc_pkg::ETH_IPV4 || len_s < 20'sd34 || rej_next ||
                     ihl_next < 6'd20 || len_s < ip_off || tot_len_next < 16'(ihl_next) ||
                     ip_dst_next != local_ip_reg || proto_next != aitc_pkg::IP_PROTO_TCP ||
                     len_s < ip_off + 20'sd20 || thl_next < 6'd20 || !conn_ok)
                verd_next = aitc_pkg::VERD_DROP;
            else if (conn_reg == aitc_pkg::CONN_SYN_SENT)
            begin
                if ((flags_next & aitc_pkg::TCP_SYNACK) == aitc_pkg::TCP_SYNACK)
                begin
                    exp_seq_next = seq_next + 32'd1;
                    conn_next = aitc_pkg::CONN_ESTABLISHED;
                    verd_next = aitc_pkg::VERD_ESTAB;
                end
            end
            else if (pay > 20'sd0 && seq_next == exp_seq_reg)
            begin
                exp_seq_next = exp_seq_reg + 32'(pay[18:0]);
                verd_next = aitc_pkg::VERD_DATA_ACK;
            end
            else if ((flags_next & aitc_pkg::TCP_FIN) != 8'd0)
            begin
                if (seq_next == exp_seq_reg)
                begin
                    exp_seq_next = exp_seq_reg + 32'd1;
                    conn_next = aitc_pkg::CONN_FIN_WAIT;
                    verd_next = aitc_pkg::VERD_FIN_ACK;
                end
            end
            else
                verd_next = aitc_pkg::VERD_BARE_ACK;

            if (verd_next == aitc_pkg::VERD_ARP_REQ || verd_next == aitc_pkg::VERD_GW_MAC)
                smac_next = arp_hw_next;
            if (verd_next == aitc_pkg::VERD_ARP_REQ)
                sip_next = arp_spa_next;
            pos_next = '0;
            rej_next = 1'b0;
            acc_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= 32'd167772687; gateway_ip_reg <= 32'd167772674;
            peer_ip_reg <= '0; local_port_reg <= '0; peer_port_reg <= '0;
            conn_reg <= aitc_pkg::CONN_CLOSED; exp_seq_reg <= '0; pos_reg <= '0;
            eth_type_reg <= '0; arp_op_reg <= '0; arp_hw_reg <= '0;
            arp_spa_reg <= '0; arp_tpa_reg <= '0; ihl_reg <= '0; thl_reg <= '0;
            tot_len_reg <= '0; proto_reg <= '0; flags_reg <= '0;
            ip_src_reg <= '0; ip_dst_reg <= '0; sport_reg <= '0; dport_reg <= '0;
            seq_reg <= '0; rej_reg <= 1'b0; acc_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                conn_reg <= conn_next; exp_seq_reg <= exp_seq_next; pos_reg <= pos_next;
                eth_type_reg <= eth_type_next; arp_op_reg <= arp_op_next;
                arp_hw_reg <= arp_hw_next; arp_spa_reg <= arp_spa_next;
                arp_tpa_reg <= arp_tpa_next; ihl_reg <= ihl_next; thl_reg <= thl_next;
                tot_len_reg <= tot_len_next; proto_reg <= proto_next;
                flags_reg <= flags_next; ip_src_reg <= ip_src_next;
                ip_dst_reg <= ip_dst_next; sport_reg <= sport_next;
                dport_reg <= dport_next; seq_reg <= seq_next;
                rej_reg <= rej_next; acc_reg <= acc_next;
            end
            if (in_fire)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
            // writes to registers 0..5 stop any stream in progress
            if (cfg_fire)
            begin
                case (cfg.index)
                    aitc_pkg::REG_LOCAL_IP:   begin local_ip_reg <= cfg.data;          acc_reg <= 1'b0; end
                    aitc_pkg::REG_GATEWAY_IP: begin gateway_ip_reg <= cfg.data;        acc_reg <= 1'b0; end
                    aitc_pkg::REG_PEER_IP:    begin peer_ip_reg <= cfg.data;           acc_reg <= 1'b0; end
                    aitc_pkg::REG_LOCAL_PORT: begin local_port_reg <= cfg.data[15:0];  acc_reg <= 1'b0; end
                    aitc_pkg::REG_PEER_PORT:  begin peer_port_reg <= cfg.data[15:0];   acc_reg <= 1'b0; end
                    aitc_pkg::REG_CONN_EN:
                    begin
                        acc_reg <= 1'b0;
                        if (cfg.data[0])
                        begin
                            conn_reg <= aitc_pkg::CONN_SYN_SENT;
                            exp_seq_reg <= '0;
                        end
                        else
                            conn_reg <= aitc_pkg::CONN_CLOSED;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pv_reg <= pv_next; pb_reg <= pb_next; done_reg <= done_next;
            verd_reg <= verd_next; smac_reg <= smac_next; sip_reg <= sip_next;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.payload_valid = pv_reg;
    assign result.payload_byte  = pb_reg;
    assign result.frame_done    = done_reg;
    assign result.verdict       = verd_reg;
    assign result.sender_mac    = smac_reg;
    assign result.sender_ip     = sip_reg;
    assign result.ack_number    = exp_seq_reg;
    assign result.conn_state    = conn_reg;

    `AITC_ASSERT_IMP(a_stall_blocks, out_vld_reg && !result.ready, !frame.ready)
    `AITC_ASSERT_IMP(a_verdict_on_done, out_vld_reg && !done_reg, verd_reg == aitc_pkg::VERD_DROP)
    `AITC_ASSERT_NXT(a_estab_state, in_fire && verd_next == aitc_pkg::VERD_ESTAB,
                     conn_reg == aitc_pkg::CONN_ESTABLISHED)
    `AITC_ASSERT_NXT(a_stream_conn, in_fire && pv_next,
                     conn_reg == aitc_pkg::CONN_ESTABLISHED || conn_reg == aitc_pkg::CONN_FIN_WAIT)
endmodule

// ----- verif/tb_arp_ipv4_tcp_receive_classifier_unit.sv -----
// Self-checking bench for the ARP/IPv4/TCP receive classifier: random and directed frames,
// a bit-true predictor and a scoreboard. Depends on aitc_pkg, aitc_ifs and the top level.
`timescale 1ns / 1ps
module tb_arp_ipv4_tcp_receive_classifier_unit;

    localparam int FRAME_CAP  = 2048;
    localparam int STALL_CAP  = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [7:0] TCP_ACK = 8'h10;
    localparam logic [7:0] TCP_PSH = 8'h08;

    logic clk;
    logic rst_n;

    aitc_frame_if  frame ();
    aitc_result_if result ();
    aitc_cfg_if    cfg ();

    arp_ipv4_tcp_receive_classifier_unit #(.MAX_FRAME(FRAME_CAP)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // One frame byte as offered on the frame channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_beat_t;

    // One expected result beat.
    typedef struct packed {
        logic        pay_vld;
        logic [7:0]  pay_byte;
        logic        done;
        logic [2:0]  verd;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] ack;
        logic [1:0]  cstate;
    } rx_outcome_t;

    rx_beat_t    beat_q[$];
    rx_outcome_t outcome_q[$];

    // Register shadows
    logic [31:0] m_local_ip, m_gw_ip, m_peer_ip;
    logic [15:0] m_local_port, m_peer_port;

    // Predictor state
    aitc_pkg::conn_state_t m_conn;
    logic [31:0] m_exp_seq;
    int unsigned m_pos;
    logic [15:0] m_etype, m_arp_op;
    logic [47:0] m_arp_mac;
    logic [31:0] m_arp_spa, m_arp_tpa;
    int unsigned m_ihl, m_ip_len, m_thl;
    logic [7:0]  m_proto, m_flags;
    logic [31:0] m_ip_src, m_ip_dst, m_seq;
    logic [15:0] m_sport, m_dport;
    logic        m_bad_ver, m_streaming;

    // Stimulus-side view of the connection; lets the generator aim at in-order seqs
    logic [31:0] m_exp_seq_sched;
    logic [31:0] cur_local, cur_gw, cur_peer;
    logic [15:0] cur_lport, cur_pport;

    int errors;
    int sender_idle_pct, receiver_idle_pct;
    bit hold_off_go;
    bit hold_off_done;
    bit hold_off_req;
    int hold_off_left;
    int quiet_cycles;

    function automatic void clear_frame_flags();
        m_pos       = 0;
        m_bad_ver   = 1'b0;
        m_streaming = 1'b0;
    endfunction

    function automatic void predictor_reset();
        m_local_ip = 32'd167772687; m_gw_ip = 32'd167772674; m_peer_ip = '0;
        m_local_port = '0; m_peer_port = '0;
        m_conn = aitc_pkg::CONN_CLOSED; m_exp_seq = '0;
        m_etype = '0; m_arp_op = '0; m_arp_mac = '0; m_arp_spa = '0; m_arp_tpa = '0;
        m_ihl = 0; m_ip_len = 0; m_thl = 0; m_proto = '0; m_flags = '0;
        m_ip_src = '0; m_ip_dst = '0; m_seq = '0; m_sport = '0; m_dport = '0;
        clear_frame_flags();
    endfunction

    function automatic void predictor_write(aitc_pkg::cfg_reg_t idx, logic [31:0] val);
        case (idx)
            aitc_pkg::REG_LOCAL_IP:   m_local_ip = val;
            aitc_pkg::REG_GATEWAY_IP: m_gw_ip = val;
            aitc_pkg::REG_PEER_IP:    m_peer_ip = val;
            aitc_pkg::REG_LOCAL_PORT: m_local_port = val[15:0];
            aitc_pkg::REG_PEER_PORT:  m_peer_port = val[15:0];
            aitc_pkg::REG_CONN_EN:
            begin
                if (val[0])
                begin
                    m_conn = aitc_pkg::CONN_SYN_SENT;
                    m_exp_seq = '0;
                end
                else
                    m_conn = aitc_pkg::CONN_CLOSED;
            end
            default: ;
        endcase
        m_streaming = 1'b0;
    endfunction

    function automatic bit conn_matches();
        return m_conn != aitc_pkg::CONN_CLOSED && m_ip_src == m_peer_ip &&
               m_dport == m_local_port && m_sport == m_peer_port;
    endfunction

    function automatic bit ip_tcp_headers_ok();
        return m_etype == aitc_pkg::ETH_IPV4 && !m_bad_ver && m_ihl >= 20 &&
               m_ip_len >= m_ihl && m_ip_dst == m_local_ip &&
               m_proto == aitc_pkg::IP_PROTO_TCP && m_thl >= 20;
    endfunction

    // Frame-end checks and the TCP receive machine.
    function automatic aitc_pkg::verdict_t classify_frame(int len);
        int ip_off, tcp_off, pay;
        if (len < 14) return aitc_pkg::VERD_DROP;
        if (m_etype == aitc_pkg::ETH_ARP)
        begin
            if (len < 42) return aitc_pkg::VERD_DROP;
            if (m_arp_op == aitc_pkg::ARP_OP_REP && m_arp_spa == m_gw_ip)
                return aitc_pkg::VERD_GW_MAC;
            if (m_arp_op == aitc_pkg::ARP_OP_REQ && m_arp_tpa == m_local_ip)
                return aitc_pkg::VERD_ARP_REQ;
            return aitc_pkg::VERD_DROP;
        end
        if (m_etype != aitc_pkg::ETH_IPV4) return aitc_pkg::VERD_DROP;
        if (len < 34 || m_bad_ver || m_ihl < 20) return aitc_pkg::VERD_DROP;
        ip_off = 14 + m_ihl;
        if (len < ip_off) return aitc_pkg::VERD_DROP;
        if (m_ip_len < m_ihl || m_ip_dst != m_local_ip) return aitc_pkg::VERD_DROP;
        if (m_proto != aitc_pkg::IP_PROTO_TCP || len < ip_off + 20) return aitc_pkg::VERD_DROP;
        if (m_thl < 20 || !conn_matches()) return aitc_pkg::VERD_DROP;
        tcp_off = ip_off + m_thl;
        pay = int'(m_ip_len) - int'(m_ihl) - int'(m_thl);
        if (pay < 0) pay = 0;
        if (tcp_off + pay > len) pay = len - tcp_off;
        if (m_conn == aitc_pkg::CONN_SYN_SENT)
        begin
            if ((m_flags & aitc_pkg::TCP_SYNACK) == aitc_pkg::TCP_SYNACK)
            begin
                m_exp_seq = m_seq + 32'd1;
                m_conn = aitc_pkg::CONN_ESTABLISHED;
                return aitc_pkg::VERD_ESTAB;
            end
            return aitc_pkg::VERD_DROP;
        end
        if (pay > 0 && m_seq == m_exp_seq)
        begin
            m_exp_seq = m_exp_seq + pay;
            return aitc_pkg::VERD_DATA_ACK;
        end
        if ((m_flags & aitc_pkg::TCP_FIN) != 0)
        begin
            if (m_seq == m_exp_seq)
            begin
                m_exp_seq = m_exp_seq + 32'd1;
                m_conn = aitc_pkg::CONN_FIN_WAIT;
                return aitc_pkg::VERD_FIN_ACK;
            end
            return aitc_pkg::VERD_DROP;
        end
        return aitc_pkg::VERD_BARE_ACK;
    endfunction

    // Byte-by-byte capture plus streaming; returns the beat the block should emit.
    function automatic rx_outcome_t classify_byte(rx_beat_t bt);
        rx_outcome_t o;
        int unsigned p, q;
        logic [7:0] b;
        aitc_pkg::verdict_t v;
        o = '0;
        b = bt.data;
        if (m_pos < FRAME_CAP)
        begin
            p = m_pos;
            if (p == 12 || p == 13) m_etype = {m_etype[7:0], b};
            if (p == 20 || p == 21) m_arp_op = {m_arp_op[7:0], b};
            if (p >= 22 && p <= 27) m_arp_mac = {m_arp_mac[39:0], b};
            if (p >= 28 && p <= 31) m_arp_spa = {m_arp_spa[23:0], b};
            if (p >= 38 && p <= 41) m_arp_tpa = {m_arp_tpa[23:0], b};
            if (p == 14)
            begin
                m_bad_ver = b[7:4] != 4'd4;
                m_ihl = b[3:0] * 4;
            end
            if (p == 16 || p == 17) m_ip_len = {m_ip_len[7:0], b};
            if (p == 23) m_proto = b;
            if (p >= 26 && p <= 29) m_ip_src = {m_ip_src[23:0], b};
            if (p >= 30 && p <= 33) m_ip_dst = {m_ip_dst[23:0], b};
            if (m_ihl >= 20 && p >= 14 + m_ihl)
            begin
                q = p - 14 - m_ihl;
                if (q <= 1) m_sport = {m_sport[7:0], b};
                else if (q <= 3) m_dport = {m_dport[7:0], b};
                else if (q <= 7) m_seq = {m_seq[23:0], b};
                else if (q == 12) m_thl = b[7:4] * 4;
                else if (q == 13) m_flags = b;
            end
            // payload decision taken on the first payload byte position
            if (m_ihl >= 20 && m_thl >= 20 && p == 14 + m_ihl + m_thl &&
                ip_tcp_headers_ok() && conn_matches() &&
                (m_conn == aitc_pkg::CONN_ESTABLISHED || m_conn == aitc_pkg::CONN_FIN_WAIT) &&
                m_seq == m_exp_seq && m_ip_len > m_ihl + m_thl)
                m_streaming = 1'b1;
            if (m_streaming && p < 14 + m_ip_len)
            begin
                o.pay_vld  = 1'b1;
                o.pay_byte = b;
            end
            m_pos = p + 1;
        end
        if (bt.last)
        begin
            v = classify_frame(int'(m_pos));
            o.done = 1'b1;
            o.verd = v;
            if (v == aitc_pkg::VERD_ARP_REQ || v == aitc_pkg::VERD_GW_MAC) o.mac = m_arp_mac;
            if (v == aitc_pkg::VERD_ARP_REQ) o.ip = m_arp_spa;
            clear_frame_flags();
        end
        o.ack    = m_exp_seq;
        o.cstate = m_conn;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Frame builders: push whole frames onto the pending byte queue.
    // ---------------------------------------------------------------
    task automatic push_bytes(input logic [7:0] fb[$]);
        foreach (fb[i])
            beat_q.push_back('{data: fb[i], last: (i == fb.size() - 1)});
    endtask

    function automatic void put16(ref logic [7:0] fb[$], input logic [15:0] v);
        fb.push_back(v[15:8]); fb.push_back(v[7:0]);
    endfunction

    function automatic void put32(ref logic [7:0] fb[$], input logic [31:0] v);
        put16(fb, v[31:16]); put16(fb, v[15:0]);
    endfunction

    function automatic void put_rand(ref logic [7:0] fb[$], input int n);
        repeat (n) fb.push_back(8'($urandom));
    endfunction

    task automatic send_arp(input logic [15:0] op, input logic [47:0] sha,
                            input logic [31:0] spa, input logic [31:0] tpa, input int pad);
        logic [7:0] fb[$];
        put_rand(fb, 12);
        put16(fb, aitc_pkg::ETH_ARP);
        put16(fb, 16'd1); put16(fb, aitc_pkg::ETH_IPV4); fb.push_back(8'd6); fb.push_back(8'd4);
        put16(fb, op);
        put16(fb, sha[47:32]); put32(fb, sha[31:0]);
        put32(fb, spa);
        put_rand(fb, 6);
        put32(fb, tpa);
        put_rand(fb, pad);
        push_bytes(fb);
    endtask

    // TCP segment; ihl/thl in words, pay bytes of data, extra bytes of trailing padding.
    task automatic send_tcp(input logic [3:0] ver, input int ihl, input logic [31:0] src,
                            input logic [31:0] dst, input logic [7:0] proto,
                            input logic [15:0] sp, input logic [15:0] dp,
                            input logic [31:0] seq, input int thl, input logic [7:0] flags,
                            input int pay, input int len_adj, input int extra);
        logic [7:0] fb[$];
        int tl;
        tl = ihl * 4 + thl * 4 + pay + len_adj;
        if (tl < 0) tl = 0;
        put_rand(fb, 12);
        put16(fb, aitc_pkg::ETH_IPV4);
        fb.push_back({ver, 4'(ihl)});
        fb.push_back(8'($urandom));
        put16(fb, 16'(tl));
        put_rand(fb, 5);
        fb.push_back(proto);
        put_rand(fb, 2);
        put32(fb, src);
        put32(fb, dst);
        put_rand(fb, ihl * 4 - 20);
        put16(fb, sp); put16(fb, dp); put32(fb, seq); put_rand(fb, 4);
        fb.push_back({4'(thl), 4'($urandom)});
        fb.push_back(flags);
        put_rand(fb, thl * 4 - 14);
        put_rand(fb, pay + extra);
        push_bytes(fb);
    endtask

    task automatic send_noise(input int n);
        logic [7:0] fb[$];
        put_rand(fb, n);
        push_bytes(fb);
    endtask

    // Well-formed segment of the live connection, mostly in order.
    task automatic send_conn_segment(input logic [7:0] flags, input int pay, input bit in_order);
        logic [31:0] s;
        s = in_order ? m_exp_seq_sched : 32'($urandom);
        send_tcp(4'd4, 5 + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 10) : 0), cur_peer,
                 cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport, s,
                 5 + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 10) : 0), flags, pay,
                 0, $urandom_range(0, 4) == 0 ? $urandom_range(1, 8) : 0);
    endtask

    // ---------------------------------------------------------------
    // Frame driver
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame.valid      <= 1'b0;
            frame.frame_byte <= '0;
            frame.frame_last <= 1'b0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                outcome_q.push_back(classify_byte('{data: frame.frame_byte,
                                                    last: frame.frame_last}));
                void'(beat_q.pop_front());
            end
            if (!frame.valid || frame.ready)
            begin
                if (beat_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    frame.valid      <= 1'b1;
                    frame.frame_byte <= beat_q[0].data;
                    frame.frame_last <= beat_q[0].last;
                end
                else
                    frame.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and scoreboard
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        rx_outcome_t want;
        rx_outcome_t got;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{result.payload_valid, result.payload_byte, result.frame_done,
                        result.verdict, result.sender_mac, result.sender_ip,
                        result.ack_number, result.conn_state};
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, actual %h", $time, got);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                    end
                end
            end
            if (hold_off_req)
                result.ready <= 1'b0;
            else
                result.ready <= $urandom_range(0, 99) >= receiver_idle_pct;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_left <= 0;
            hold_off_req  <= 1'b0;
            hold_off_done <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
            hold_off_req  <= 1'b1;
        end
        else if (hold_off_go && !hold_off_done)
        begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
            hold_off_req  <= 1'b1;
        end
        else
            hold_off_req <= 1'b0;
    end

    // Watchdog: ends the run when nothing is accepted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (frame.valid && frame.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_CAP)
        begin
            $display("arp_ipv4_tcp_receive_classifier_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Register writes; only called while the block is idle.
    // ---------------------------------------------------------------
    task automatic write_reg(input aitc_pkg::cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        predictor_write(idx, val);
        cfg.valid <= 1'b0;
        if (idx == aitc_pkg::REG_CONN_EN && val[0]) m_exp_seq_sched = '0;
    endtask

    task automatic drain();
        while (beat_q.size() != 0 || outcome_q.size() != 0 || frame.valid)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic program_connection(input logic [31:0] lip, input logic [31:0] gip,
                                      input logic [31:0] pip, input logic [15:0] lp,
                                      input logic [15:0] pp);
        drain();
        cur_local = lip; cur_gw = gip; cur_peer = pip; cur_lport = lp; cur_pport = pp;
        write_reg(aitc_pkg::REG_LOCAL_IP, lip);
        write_reg(aitc_pkg::REG_GATEWAY_IP, gip);
        write_reg(aitc_pkg::REG_PEER_IP, pip);
        write_reg(aitc_pkg::REG_LOCAL_PORT, {16'($urandom), lp});
        write_reg(aitc_pkg::REG_PEER_PORT, {16'($urandom), pp});
        write_reg(aitc_pkg::REG_CONN_EN, 32'd1);
    endtask

    // Handshake, data, FIN on the live connection with random noise mixed in.
    task automatic run_session(input int n_frames, input int max_pay);
        int k, pick, pay;
        send_conn_segment(aitc_pkg::TCP_SYNACK | ($urandom_range(0, 1) ? TCP_ACK : 8'h00),
                          0, 1'b0);
        // the block learns seq+1 from the handshake; pick it up once settled
        m_exp_seq_sched = 'x;
        drain();
        m_exp_seq_sched = m_exp_seq;
        for (k = 0; k < n_frames; k++)
        begin
            pick = $urandom_range(0, 99);
            pay  = $urandom_range(0, 9) == 0 ? $urandom_range(0, max_pay)
                                             : $urandom_range(0, 12);
            if (pick < 55)
            begin
                send_conn_segment(TCP_ACK | ($urandom_range(0, 1) ? TCP_PSH : 8'h00), pay, 1'b1);
                if (pay > 0) m_exp_seq_sched += pay;
            end
            else if (pick < 62)
            begin
                send_conn_segment(TCP_ACK | aitc_pkg::TCP_FIN, pay, 1'b1);
                m_exp_seq_sched += (pay > 0) ? pay : 1;
            end
            else if (pick < 72)
                send_conn_segment(8'($urandom), pay, 1'($urandom_range(0, 1)));
            else if (pick < 80)
                send_arp($urandom_range(0, 1) ? aitc_pkg::ARP_OP_REQ : aitc_pkg::ARP_OP_REP,
                         {16'($urandom), 32'($urandom)},
                         $urandom_range(0, 1) ? cur_gw : 32'($urandom),
                         $urandom_range(0, 1) ? cur_local : 32'($urandom),
                         $urandom_range(0, 20));
            else if (pick < 88)
                send_tcp(4'($urandom), $urandom_range(0, 15), $urandom_range(0, 1) ? cur_peer
                         : 32'($urandom), $urandom_range(0, 3) ? cur_local : 32'($urandom),
                         $urandom_range(0, 3) ? aitc_pkg::IP_PROTO_TCP : 8'($urandom),
                         $urandom_range(0, 3) ? cur_pport : 16'($urandom),
                         $urandom_range(0, 3) ? cur_lport : 16'($urandom), 32'($urandom),
                         $urandom_range(0, 15), 8'($urandom), $urandom_range(0, 10),
                         int'($urandom_range(0, 20)) - 10, $urandom_range(0, 4));
            else
                send_noise($urandom_range(1, 60));
            // the scheduler's view can drift after broken frames; resync while idle
            if (k % 8 == 7)
            begin
                drain();
                m_exp_seq_sched = m_exp_seq;
            end
        end
    endtask

    initial
    begin
        int phase;
        sender_idle_pct = 36;
        receiver_idle_pct = 77;
        hold_off_go = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = aitc_pkg::REG_LOCAL_IP;
        cfg.data = '0;
        predictor_reset();
        m_exp_seq_sched = '0;
        cur_local = 32'd167772687; cur_gw = 32'd167772674; cur_peer = '0;
        cur_lport = '0; cur_pport = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: defaults, closed connection, ARP, short frames, bad headers
        send_arp(aitc_pkg::ARP_OP_REQ, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, cur_local, 0);
        send_arp(aitc_pkg::ARP_OP_REP, 48'h0, cur_gw, 32'h0, 18);
        send_arp(aitc_pkg::ARP_OP_REP, 48'h1234_5678_9ABC, 32'h0, cur_local, 0);
        send_noise(1);
        send_noise(13);
        send_noise(41);
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, 0, 0, 0, 5,
                 aitc_pkg::TCP_SYNACK, 0, 0, 0);
        program_connection(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_tcp(4'd6, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 0, 5, aitc_pkg::TCP_SYNACK, 0, 0, 0);
        send_tcp(4'd4, 4, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 0, 5, aitc_pkg::TCP_SYNACK, 0, 0, 0);
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 0, 4, aitc_pkg::TCP_SYNACK, 0, 0, 0);
        send_tcp(4'd4, 5, cur_peer, cur_local, 8'd17, cur_pport, cur_lport,
                 0, 5, aitc_pkg::TCP_SYNACK, 0, 0, 0);
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 0, 5, TCP_ACK, 0, 0, 0);
        send_tcp(4'd4, 15, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 32'hFFFF_FFFF, 15, 8'hFF, 0, 0, 0);
        drain();
        m_exp_seq_sched = m_exp_seq;
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 m_exp_seq_sched, 5, TCP_ACK | TCP_PSH, 6, -3, 5);
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 32'd7, 5, aitc_pkg::TCP_FIN, 0, 0, 0);
        drain();
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 m_exp_seq, 5, TCP_ACK | aitc_pkg::TCP_FIN, 0, 0, 0);
        drain();
        // longer in-order stream followed by link padding
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 m_exp_seq, 5, TCP_ACK, 40, 0, 6);
        drain();
        write_reg(aitc_pkg::REG_CONN_EN, 32'd0);
        send_tcp(4'd4, 5, cur_peer, cur_local, aitc_pkg::IP_PROTO_TCP, cur_pport, cur_lport,
                 m_exp_seq, 5, TCP_ACK, 4, 0, 0);

        // Random phases with varied register settings and idling patterns
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                sender_idle_pct = 77;
                receiver_idle_pct = 36;
            end
            if (phase == 2)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            case (phase % 3)
                0: program_connection(32'h0, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0);
                default: program_connection(32'($urandom), 32'($urandom), 32'($urandom),
                                            16'($urandom), 16'($urandom));
            endcase
            if (phase == 2) hold_off_go = 1'b1;
            run_session(2, 40);
        end

        drain();
        if (errors == 0)
            $display("arp_ipv4_tcp_receive_classifier_unit verification clean");
        else
            $display("arp_ipv4_tcp_receive_classifier_unit verification failed");
        $finish;
    end
endmodule
